// ----- src/ping_frame_receiver_with_policing_defines.svh -----
// Assertion macros shared by the checker of the PING frame receiver.
`ifndef PING_FRAME_RECEIVER_WITH_POLICING_DEFINES_SVH
`define PING_FRAME_RECEIVER_WITH_POLICING_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define PFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define PFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pfr_pkg.sv -----
// Types, constants and codes of the PING frame receiver.
`default_nettype none
package pfr_pkg;

    localparam int unsigned OPC_W      = 2;
    localparam int unsigned LEN_W      = 24;
    localparam int unsigned FLAG_W     = 8;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OPAQUE_W   = 64;
    localparam int unsigned TIME_W     = 48;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned MIN_INT_W  = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Item codes
    localparam logic [OPC_W-1:0] OPC_BEGIN = 2'd0;
    localparam logic [OPC_W-1:0] OPC_BYTE  = 2'd1;
    localparam logic [OPC_W-1:0] OPC_TICK  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERMIT_IDLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_SERVER    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_ACK  = 2'd3;

    // Frame constants
    localparam int unsigned PAYLOAD_BYTES = 8;
    localparam logic [LEN_W-1:0]  PAYLOAD_LEN   = LEN_W'(PAYLOAD_BYTES);
    localparam logic [CNT_W-1:0]  PAYLOAD_CNT   = CNT_W'(PAYLOAD_BYTES);
    localparam logic [CNT_W-1:0]  LAST_CNT      = CNT_W'(PAYLOAD_BYTES - 1);
    localparam logic [FLAG_W-1:0] FLAG_BAD_MASK = 8'hfe;

    localparam int unsigned IDLE_SECONDS         = 7200;
    localparam int unsigned TICKS_PER_SECOND_DEF = 1000;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [LEN_W-1:0]  frame_length;
        logic [FLAG_W-1:0] frame_flags;
        logic [BYTE_W-1:0] data_byte;
        logic              streams_open;
    } item_t;

    typedef struct packed {
        logic                status;
        logic                frame_done;
        logic                ack_received;
        logic                send_ack;
        logic                strike;
        logic [OPAQUE_W-1:0] opaque_value;
    } result_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_wr_t;

endpackage
`default_nettype wire

// ----- src/pfr_in_reg.sv -----
// Input register stage: captures one beat and holds it until the engine takes it.
`default_nettype none
module pfr_in_reg
    import pfr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire item_t s_item,
    input  wire logic  advance,
    output logic       in_valid,
    output item_t      in_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Take a new beat whenever the stage is empty or drains this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule
`default_nettype wire

// ----- src/pfr_engine.sv -----
// Frame state, configuration registers, opaque accumulation and ping policing.
`default_nettype none
module pfr_engine
    import pfr_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cfg_wr_t cfg,
    input  wire logic    fire,
    input  wire item_t   item,
    output result_t      result
);

    localparam logic [TIME_W-1:0] IDLE_GAP =
        TIME_W'(64'(IDLE_SECONDS) * 64'(TICKS_PER_SECOND));

    logic [MIN_INT_W-1:0] min_interval_reg;
    logic                 permit_idle_reg;
    logic                 is_server_reg;
    logic                 disable_ack_reg;

    logic [CNT_W-1:0]    byte_count_reg, byte_count_next;
    logic                ack_flag_reg, ack_flag_next;
    logic [OPAQUE_W-1:0] accum_reg, accum_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   last_ping_reg, last_ping_next;

    logic [TIME_W-1:0]   gap;
    logic [TIME_W:0]     deadline;
    logic                early;
    logic                header_bad;

    // Policing compare: deadline formed one bit wider, no wrap
    assign gap      = (!permit_idle_reg && !item.streams_open)
                      ? IDLE_GAP : TIME_W'(min_interval_reg);
    assign deadline = {1'b0, last_ping_reg} + {1'b0, gap};
    assign early    = deadline > {1'b0, now_reg};

    assign header_bad = ((item.frame_flags & FLAG_BAD_MASK) != '0)
                        || (item.frame_length != PAYLOAD_LEN);

    // Decode the beat
    always_comb begin
        result          = '0;
        byte_count_next = byte_count_reg;
        ack_flag_next   = ack_flag_reg;
        accum_next      = accum_reg;
        now_next        = now_reg;
        last_ping_next  = last_ping_reg;
        case (item.opcode)
            OPC_BEGIN: begin
                if (header_bad) begin
                    result.status = 1'b1;
                end else begin
                    byte_count_next = '0;
                    ack_flag_next   = item.frame_flags[0];
                    accum_next      = '0;
                end
            end
            OPC_BYTE: begin
                if (byte_count_reg < PAYLOAD_CNT) begin
                    // Shift in most significant byte first
                    accum_next      = {accum_reg[OPAQUE_W-BYTE_W-1:0], item.data_byte};
                    byte_count_next = byte_count_reg + 1'b1;
                    if (byte_count_reg == LAST_CNT) begin
                        result.frame_done   = 1'b1;
                        result.opaque_value = accum_next;
                        if (ack_flag_reg) begin
                            result.ack_received = 1'b1;
                        end else begin
                            if (is_server_reg) begin
                                result.strike  = early;
                                last_ping_next = now_reg;
                            end
                            result.send_ack = !disable_ack_reg;
                        end
                    end
                end
            end
            OPC_TICK: begin
                now_next = now_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Advance frame and time state on each beat taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= PAYLOAD_CNT;
            ack_flag_reg   <= 1'b0;
            accum_reg      <= '0;
            now_reg        <= '0;
            last_ping_reg  <= '0;
        end else if (fire) begin
            byte_count_reg <= byte_count_next;
            ack_flag_reg   <= ack_flag_next;
            accum_reg      <= accum_next;
            now_reg        <= now_next;
            last_ping_reg  <= last_ping_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_interval_reg <= '0;
            permit_idle_reg  <= 1'b0;
            is_server_reg    <= 1'b0;
            disable_ack_reg  <= 1'b0;
        end else if (cfg.we) begin
            case (cfg.addr)
                CFG_MIN_INTERVAL: min_interval_reg <= MIN_INT_W'(cfg.wdata);
                CFG_PERMIT_IDLE:  permit_idle_reg  <= cfg.wdata[0];
                CFG_IS_SERVER:    is_server_reg    <= cfg.wdata[0];
                CFG_DISABLE_ACK:  disable_ack_reg  <= cfg.wdata[0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/pfr_out_reg.sv -----
// Result register: holds one result beat until the downstream side takes it.
`default_nettype none
module pfr_out_reg
    import pfr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    input  wire result_t in_result,
    output logic         advance,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Load when empty or when the held beat leaves this cycle
    assign advance    = !valid_reg || m_ready;
    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            result_reg <= in_result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule
`default_nettype wire

// ----- src/ping_frame_receiver_with_policing.sv -----
// An accepted beat is held in the input register; its result beat is then held in
// the result register. Throughput: one input beat per cycle unless m_ready stalls;
// each register takes a new beat in the cycle the next stage frees it.
// Every input beat gives exactly one result beat.
// Reset (aresetn low, synchronous) empties both stages, closes any frame,
// clears the time and last ping counters and sets all configuration registers to 0.
`default_nettype none
module ping_frame_receiver_with_policing
    import pfr_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OPC_W-1:0]      s_opcode,
    input  wire logic [LEN_W-1:0]      s_frame_length,
    input  wire logic [FLAG_W-1:0]     s_frame_flags,
    input  wire logic [BYTE_W-1:0]     s_data_byte,
    input  wire logic                  s_streams_open,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_status,
    output logic                       m_frame_done,
    output logic                       m_ack_received,
    output logic                       m_send_ack,
    output logic                       m_strike,
    output logic [OPAQUE_W-1:0]        m_opaque_value
);

    item_t   s_item;
    item_t   in_item;
    logic    in_valid;
    logic    advance;
    cfg_wr_t cfg;
    result_t eng_result;
    result_t m_result;

    // Gather port fields
    assign s_item = '{opcode:       s_opcode,
                      frame_length: s_frame_length,
                      frame_flags:  s_frame_flags,
                      data_byte:    s_data_byte,
                      streams_open: s_streams_open};
    assign cfg = '{we: cfg_we, addr: cfg_addr, wdata: cfg_wdata};

    pfr_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    pfr_engine #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (in_valid && advance),
        .item    (in_item),
        .result  (eng_result)
    );

    pfr_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_result (eng_result),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    // Spread result fields onto ports
    assign m_status       = m_result.status;
    assign m_frame_done   = m_result.frame_done;
    assign m_ack_received = m_result.ack_received;
    assign m_send_ack     = m_result.send_ack;
    assign m_strike       = m_result.strike;
    assign m_opaque_value = m_result.opaque_value;

endmodule
`default_nettype wire

// ----- src/pfr_checker.sv -----
// Port-level checks of the PING frame receiver and their binding to the top level.
`default_nettype none
`include "ping_frame_receiver_with_policing_defines.svh"
module pfr_checker
    import pfr_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic                m_status,
    input wire logic                m_frame_done,
    input wire logic                m_ack_received,
    input wire logic                m_send_ack,
    input wire logic                m_strike,
    input wire logic [OPAQUE_W-1:0] m_opaque_value
);

    // A stalled result beat holds
    `PFR_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_opaque_value), "result beat changed while stalled")

    // A received ACK only on a completed frame, never with a reply or strike
    `PFR_ASSERT_IMP(a_ack_rx, m_valid && m_ack_received, m_frame_done && !m_send_ack && !m_strike, "ack_received outside a completed frame")

    // Reply and strike only on a completed non-ACK frame
    `PFR_ASSERT_IMP(a_reply, m_valid && (m_send_ack || m_strike), m_frame_done && !m_ack_received, "send_ack or strike without a completed ping")

    // Opaque is zero unless a frame completed, and header errors complete nothing
    `PFR_ASSERT_IMP(a_opaque, m_valid && !m_frame_done, m_opaque_value == '0, "opaque value set without a completed frame")

    `PFR_ASSERT_IMP(a_status, m_valid && m_status, !m_frame_done, "header error on a completing beat")

endmodule

bind ping_frame_receiver_with_policing pfr_checker u_pfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_frame_done   (m_frame_done),
    .m_ack_received (m_ack_received),
    .m_send_ack     (m_send_ack),
    .m_strike       (m_strike),
    .m_opaque_value (m_opaque_value)
);
`default_nettype wire

// ----- verif/ping_frame_receiver_with_policing_tb.sv -----
// Self-checking testbench for the PING frame receiver with ping-rate policing.
`timescale 1ns / 1ps

module ping_frame_receiver_with_policing_tb;
    import pfr_pkg::*;

    localparam int unsigned PING_TICKS_PER_SEC = TICKS_PER_SECOND_DEF;
    localparam logic [OPC_W-1:0] OPC_UNUSED = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned PHASE_COUNT = 6;
    localparam int unsigned BEATS_PER_HALF = 40;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic  s_valid = 1'b0;
    logic  s_ready;
    item_t drv_beat = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_status;
    logic                m_frame_done;
    logic                m_ack_received;
    logic                m_send_ack;
    logic                m_strike;
    logic [OPAQUE_W-1:0] m_opaque_value;

    // Predictor state and its copy of the registers
    logic [CNT_W-1:0]     rx_count = PAYLOAD_CNT;
    logic                 rx_ack = 1'b0;
    logic [OPAQUE_W-1:0]  rx_opaque = '0;
    logic [TIME_W-1:0]    now_ticks = '0;
    logic [TIME_W-1:0]    last_ping = '0;
    logic [MIN_INT_W-1:0] cfg_min_interval = '0;
    logic                 cfg_permit_idle = 1'b0;
    logic                 cfg_server = 1'b0;
    logic                 cfg_no_ack = 1'b0;

    item_t       pending_beats[$];
    result_t     expected_results[$];
    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned sink_stall = 0;
    bit          in_taken = 1'b0;
    bit          out_taken = 1'b0;
    bit          no_idle = 1'b0;

    ping_frame_receiver_with_policing #(
        .TICKS_PER_SECOND(PING_TICKS_PER_SEC)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (drv_beat.opcode),
        .s_frame_length(drv_beat.frame_length),
        .s_frame_flags (drv_beat.frame_flags),
        .s_data_byte   (drv_beat.data_byte),
        .s_streams_open(drv_beat.streams_open),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_frame_done  (m_frame_done),
        .m_ack_received(m_ack_received),
        .m_send_ack    (m_send_ack),
        .m_strike      (m_strike),
        .m_opaque_value(m_opaque_value)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Advance the predictor by one accepted beat and return its result
    function automatic result_t predict_ping_result(input item_t it);
        result_t          res;
        logic [TIME_W:0]  gap;
        logic [TIME_W:0]  allowed;
        res = '0;
        case (it.opcode)
            OPC_BEGIN: begin
                if ((it.frame_flags & FLAG_BAD_MASK) != '0 || it.frame_length != PAYLOAD_LEN) begin
                    res.status = 1'b1;
                end else begin
                    rx_count = '0;
                    rx_ack = it.frame_flags[0];
                    rx_opaque = '0;
                end
            end
            OPC_BYTE: begin
                if (rx_count < PAYLOAD_CNT) begin
                    // most significant byte first
                    rx_opaque[8 * (LAST_CNT - rx_count) +: 8] = it.data_byte;
                    rx_count = rx_count + 1'b1;
                    if (rx_count == PAYLOAD_CNT) begin
                        res.frame_done = 1'b1;
                        res.opaque_value = rx_opaque;
                        if (rx_ack) begin
                            res.ack_received = 1'b1;
                        end else begin
                            if (cfg_server) begin
                                if (!cfg_permit_idle && !it.streams_open)
                                    gap = (TIME_W + 1)'(IDLE_SECONDS * PING_TICKS_PER_SEC);
                                else
                                    gap = (TIME_W + 1)'(cfg_min_interval);
                                allowed = {1'b0, last_ping} + gap;
                                res.strike = allowed > {1'b0, now_ticks};
                                last_ping = now_ticks;
                            end
                            res.send_ack = !cfg_no_ack;
                        end
                    end
                end
            end
            OPC_TICK: begin
                now_ticks = now_ticks + 1'b1;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Mostly short gaps, a few long ones, none while no_idle is set
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic item_t random_beat(input logic [OPC_W-1:0] opc);
        item_t it;
        it.opcode = opc;
        it.frame_length = LEN_W'($urandom);
        it.frame_flags = FLAG_W'($urandom);
        it.data_byte = BYTE_W'($urandom);
        it.streams_open = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic queue_beat(input item_t it);
        pending_beats.push_back(it);
        n_queued++;
    endtask

    // Valid header followed by n_bytes payload beats, ticks sprinkled in
    task automatic queue_frame(input bit ack_frame, input int unsigned n_bytes);
        item_t       it;
        int unsigned i;
        it = random_beat(OPC_BEGIN);
        it.frame_length = PAYLOAD_LEN;
        it.frame_flags = {7'd0, ack_frame};
        queue_beat(it);
        for (i = 0; i < n_bytes; i++) begin
            if ($urandom_range(0, 9) == 0)
                queue_beat(random_beat(OPC_TICK));
            queue_beat(random_beat(OPC_BYTE));
        end
    endtask

    task automatic queue_bad_header();
        item_t it;
        it = random_beat(OPC_BEGIN);
        case ($urandom_range(0, 2))
            0: it.frame_length = PAYLOAD_LEN;
            1: it.frame_flags[FLAG_W-1:1] = '0;
            default: begin
            end
        endcase
        if (it.frame_length == PAYLOAD_LEN && (it.frame_flags & FLAG_BAD_MASK) == '0)
            it.frame_flags[1] = 1'b1;
        queue_beat(it);
    endtask

    // Mostly whole frames with random content, the rest noise
    task automatic queue_random(input int unsigned n_beats);
        int unsigned base;
        int unsigned r;
        base = n_queued;
        while (n_queued - base < n_beats) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                queue_frame($urandom_range(0, 4) == 0, PAYLOAD_BYTES);
                repeat ($urandom_range(0, 12)) queue_beat(random_beat(OPC_TICK));
            end else if (r < 75) begin
                queue_frame(1'($urandom_range(0, 1)), $urandom_range(0, PAYLOAD_BYTES - 1));
            end else if (r < 85) begin
                queue_bad_header();
            end else if (r < 92) begin
                queue_beat(random_beat(OPC_BYTE));
            end else begin
                queue_beat(random_beat(OPC_W'($urandom_range(0, 3))));
            end
        end
    endtask

    // Hold until every queued beat is taken and every result is back
    task automatic wait_all_done();
        while (n_accepted != n_queued || expected_results.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic set_config(input logic [MIN_INT_W-1:0] min_interval, input bit permit_idle,
                              input bit server, input bit no_ack);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_MIN_INTERVAL;
        cfg_wdata <= CFG_DATA_W'(min_interval);
        @(negedge aclk);
        cfg_addr <= CFG_PERMIT_IDLE;
        cfg_wdata <= CFG_DATA_W'(permit_idle);
        @(negedge aclk);
        cfg_addr <= CFG_IS_SERVER;
        cfg_wdata <= CFG_DATA_W'(server);
        @(negedge aclk);
        cfg_addr <= CFG_DISABLE_ACK;
        cfg_wdata <= CFG_DATA_W'(no_ack);
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_min_interval = min_interval;
        cfg_permit_idle = permit_idle;
        cfg_server = server;
        cfg_no_ack = no_ack;
    endtask

    // Input driver: hold the beat until taken, then advance after a gap
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !in_taken)) begin
            if (send_gap != 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (pending_beats.size() != 0) begin
                drv_beat <= pending_beats.pop_front();
                s_valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result sink: stall at random after beats and now and then on its own
    always @(negedge aclk) begin
        if (out_taken)
            sink_stall = pick_gap();
        else if (sink_stall == 0 && !no_idle && $urandom_range(0, 15) == 0)
            sink_stall = $urandom_range(1, 4);
        if (sink_stall != 0) begin
            m_ready <= 1'b0;
            sink_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on input beats, check result beats, watch for a hang
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        in_taken = aresetn && s_valid && s_ready;
        out_taken = aresetn && m_valid && m_ready;
        if (in_taken) begin
            expected_results.push_back(predict_ping_result(drv_beat));
            n_accepted++;
        end
        if (out_taken) begin
            got = {m_status, m_frame_done, m_ack_received, m_send_ack, m_strike, m_opaque_value};
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with none expected, got %0h", $time, got);
            end else begin
                want = expected_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("frame_done", want.frame_done, got.frame_done);
                check_field("ack_received", want.ack_received, got.ack_received);
                check_field("send_ack", want.send_ack, got.send_ack);
                check_field("strike", want.strike, got.strike);
                check_field("opaque_value", want.opaque_value, got.opaque_value);
            end
        end
        if (in_taken || out_taken)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        item_t       it;
        int unsigned phase;
        int unsigned i;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with the registers at reset values (client side)
        it = random_beat(OPC_BEGIN);
        it.frame_length = PAYLOAD_LEN;
        it.frame_flags = FLAG_BAD_MASK;
        queue_beat(it);
        it = random_beat(OPC_BEGIN);
        it.frame_length = {LEN_W{1'b1}};
        it.frame_flags = '0;
        queue_beat(it);
        queue_beat(random_beat(OPC_UNUSED));
        // stray byte with no frame open
        queue_beat(random_beat(OPC_BYTE));
        queue_frame(1'b0, 3);
        // valid header restarts the open frame as an ACK
        it = random_beat(OPC_BEGIN);
        it.frame_length = PAYLOAD_LEN;
        it.frame_flags = 8'h01;
        queue_beat(it);
        // bad header leaves the frame open
        it = random_beat(OPC_BEGIN);
        it.frame_length = '0;
        it.frame_flags = '0;
        queue_beat(it);
        for (i = 0; i < PAYLOAD_BYTES; i++) begin
            it = random_beat(OPC_BYTE);
            it.data_byte = 8'hff;
            queue_beat(it);
        end
        // byte after the eighth is dropped
        it = random_beat(OPC_BYTE);
        it.data_byte = 8'h00;
        queue_beat(it);
        queue_beat(random_beat(OPC_TICK));
        wait_all_done();

        // Random phases, each under its own register setting
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: set_config({MIN_INT_W{1'b1}}, 1'b1, 1'b1, 1'b0);
                1: set_config('0, 1'b0, 1'b1, 1'b1);
                2: set_config(MIN_INT_W'($urandom_range(0, 20)), 1'b1, 1'b1, 1'b0);
                3: set_config(MIN_INT_W'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                4: set_config(MIN_INT_W'($urandom_range(0, 20)), 1'b0, 1'b1, 1'b0);
                default: set_config('0, 1'b0, 1'b0, 1'b0);
            endcase
            no_idle = (phase == 2);
            queue_random(BEATS_PER_HALF);
            // let the sender sit until everything is back, then carry on
            wait_all_done();
            queue_random(BEATS_PER_HALF);
            wait_all_done();
        end
        no_idle = 1'b0;

        wait_all_done();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/pfr_pkg.sv
src/pfr_in_reg.sv
src/pfr_engine.sv
src/pfr_out_reg.sv
src/ping_frame_receiver_with_policing.sv
src/pfr_checker.sv
verif/ping_frame_receiver_with_policing_tb.sv
